// File: rtl/core/cube_map_face_and_uv_macros.svh
// Assertion macros for the cube map face and uv block.
// Each macro samples on clk and is disabled while rst_n is low.
`ifndef CUBE_MAP_FACE_AND_UV_MACROS_SVH
`define CUBE_MAP_FACE_AND_UV_MACROS_SVH

// Same-cycle implication.
`define CMUV_ASSERT_IMPLY(label, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error("cube map assertion failed");

// Implication after a constant number of cycles.
`define CMUV_ASSERT_DELAY(label, cond, dly, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> ##dly (prop)) \
        else $error("cube map latency assertion failed");

`endif

// File: rtl/core/cmuv_pkg.sv
package cmuv_pkg;

    localparam logic [2:0] FACE_NEG_X = 3'd0;
    localparam logic [2:0] FACE_POS_X = 3'd1;
    localparam logic [2:0] FACE_NEG_Y = 3'd2;
    localparam logic [2:0] FACE_POS_Y = 3'd3;
    localparam logic [2:0] FACE_NEG_Z = 3'd4;
    localparam logic [2:0] FACE_POS_Z = 3'd5;

    typedef struct packed {
        logic [2:0] face;
        logic       zero;
    } info_t;

endpackage

// File: rtl/core/cmuv_face_sel.sv
module cmuv_face_sel #(
    parameter int COMP_BITS = 16
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    input  logic signed [COMP_BITS-1:0] dir_x,
    input  logic signed [COMP_BITS-1:0] dir_y,
    input  logic signed [COMP_BITS-1:0] dir_z,
    output logic                        out_valid,
    output cmuv_pkg::info_t             out_info,
    output logic [COMP_BITS-1:0]        major,
    output logic signed [COMP_BITS:0]   comp_u,
    output logic signed [COMP_BITS:0]   comp_v
);

    logic signed [COMP_BITS:0]   xe;
    logic signed [COMP_BITS:0]   ye;
    logic signed [COMP_BITS:0]   ze;
    logic signed [COMP_BITS:0]   ax_w;
    logic signed [COMP_BITS:0]   ay_w;
    logic signed [COMP_BITS:0]   az_w;
    logic [COMP_BITS-1:0]        ax;
    logic [COMP_BITS-1:0]        ay;
    logic [COMP_BITS-1:0]        az;
    logic                        use_x;
    logic                        use_y;

    logic                        valid_reg;
    cmuv_pkg::info_t             info_reg;
    cmuv_pkg::info_t             info_next;
    logic [COMP_BITS-1:0]        major_reg;
    logic [COMP_BITS-1:0]        major_next;
    logic signed [COMP_BITS:0]   cu_reg;
    logic signed [COMP_BITS:0]   cu_next;
    logic signed [COMP_BITS:0]   cv_reg;
    logic signed [COMP_BITS:0]   cv_next;

    assign xe   = COMP_BITS'(1) == 0 ? '0 : {dir_x[COMP_BITS-1], dir_x};
    assign ye   = {dir_y[COMP_BITS-1], dir_y};
    assign ze   = {dir_z[COMP_BITS-1], dir_z};
    assign ax_w = xe[COMP_BITS] ? -xe : xe;
    assign ay_w = ye[COMP_BITS] ? -ye : ye;
    assign az_w = ze[COMP_BITS] ? -ze : ze;
    assign ax   = ax_w[COMP_BITS-1:0];
    assign ay   = ay_w[COMP_BITS-1:0];
    assign az   = az_w[COMP_BITS-1:0];

    assign use_x = (ax > az) && (ax > ay);
    assign use_y = !use_x && ((ax > az) || (ay > az));

    always_comb
    begin
        info_next.zero = (dir_x == '0) && (dir_y == '0) && (dir_z == '0);
        if (use_x)
        begin
            major_next = ax;
            cv_next    = ze;
            if (xe[COMP_BITS])
            begin
                info_next.face = cmuv_pkg::FACE_NEG_X;
                cu_next        = ye;
            end
            else
            begin
                info_next.face = cmuv_pkg::FACE_POS_X;
                cu_next        = -ye;
            end
        end
        else if (use_y)
        begin
            major_next = ay;
            cv_next    = ze;
            if (ye[COMP_BITS])
            begin
                info_next.face = cmuv_pkg::FACE_NEG_Y;
                cu_next        = -xe;
            end
            else
            begin
                info_next.face = cmuv_pkg::FACE_POS_Y;
                cu_next        = xe;
            end
        end
        else
        begin
            major_next = az;
            cu_next    = xe;
            if (ze[COMP_BITS])
            begin
                info_next.face = cmuv_pkg::FACE_NEG_Z;
                cv_next        = ye;
            end
            else
            begin
                info_next.face = cmuv_pkg::FACE_POS_Z;
                cv_next        = -ye;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        info_reg  <= info_next;
        major_reg <= major_next;
        cu_reg    <= cu_next;
        cv_reg    <= cv_next;
    end

    assign out_valid = valid_reg;
    assign out_info  = info_reg;
    assign major     = major_reg;
    assign comp_u    = cu_reg;
    assign comp_v    = cv_reg;

endmodule

// File: rtl/core/cmuv_div_pipe.sv
module cmuv_div_pipe #(
    parameter int COMP_BITS    = 16,
    parameter int UV_FRAC_BITS = 16
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    input  cmuv_pkg::info_t             in_info,
    input  logic [COMP_BITS-1:0]        major,
    input  logic signed [COMP_BITS:0]   comp_u,
    input  logic signed [COMP_BITS:0]   comp_v,
    output logic                        out_valid,
    output cmuv_pkg::info_t             out_info,
    output logic [UV_FRAC_BITS:0]       u_coord,
    output logic [UV_FRAC_BITS:0]       v_coord
);

    localparam int F = UV_FRAC_BITS;
    localparam logic [F:0] UV_HALF = (F + 1)'(1) << (F - 1);

    logic                  valid_reg [0:F];
    cmuv_pkg::info_t       info_reg  [0:F];
    logic [COMP_BITS-1:0]  n_reg     [0:F];
    logic [COMP_BITS-1:0]  r_reg     [0:F][0:1];
    logic [F:0]            q_reg     [0:F][0:1];

    logic signed [COMP_BITS:0] comp_in [0:1];
    logic signed [COMP_BITS:0] n_ext;

    logic                  done_reg;
    cmuv_pkg::info_t       done_info_reg;
    logic [F:0]            coord_reg [0:1];

    assign comp_in[0] = comp_u;
    assign comp_in[1] = comp_v;
    assign n_ext      = {1'b0, major};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s <= F; s++)
            begin
                valid_reg[s] <= 1'b0;
            end
            done_reg <= 1'b0;
        end
        else
        begin
            valid_reg[0] <= in_valid;
            for (int s = 1; s <= F; s++)
            begin
                valid_reg[s] <= valid_reg[s-1];
            end
            done_reg <= valid_reg[F];
        end
    end

    always_ff @(posedge clk)
    begin
        info_reg[0] <= in_info;
        n_reg[0]    <= major;
        for (int s = 1; s <= F; s++)
        begin
            info_reg[s] <= info_reg[s-1];
            n_reg[s]    <= n_reg[s-1];
        end
        done_info_reg <= info_reg[F];
    end

    for (genvar l = 0; l < 2; l++)
    begin : g_lane
        logic [COMP_BITS:0] a_sum;
        logic               q_int;
        logic [COMP_BITS-1:0] r_last;
        logic [COMP_BITS-1:0] n_last;
        logic [F:0]           q_round;

        assign a_sum = n_ext + comp_in[l];
        assign q_int = (comp_in[l] == n_ext);

        always_ff @(posedge clk)
        begin
            q_reg[0][l] <= {{F{1'b0}}, q_int};
            r_reg[0][l] <= q_int ? '0 : a_sum[COMP_BITS-1:0];
        end

        for (genvar s = 1; s <= F; s++)
        begin : g_step
            logic [COMP_BITS:0] two_r;
            logic [COMP_BITS:0] dd;
            logic [COMP_BITS:0] diff;
            logic               q_bit;

            assign two_r = {r_reg[s-1][l], 1'b0};
            assign dd    = {n_reg[s-1], 1'b0};
            assign diff  = two_r - dd;
            assign q_bit = (two_r >= dd);

            always_ff @(posedge clk)
            begin
                q_reg[s][l] <= {q_reg[s-1][l][F-1:0], q_bit};
                r_reg[s][l] <= q_bit ? diff[COMP_BITS-1:0] : two_r[COMP_BITS-1:0];
            end
        end

        assign r_last  = r_reg[F][l];
        assign n_last  = n_reg[F];
        assign q_round = q_reg[F][l] + {{F{1'b0}}, (r_last >= n_last)};

        always_ff @(posedge clk)
        begin
            coord_reg[l] <= info_reg[F].zero ? UV_HALF : q_round;
        end
    end

    assign out_valid = done_reg;
    assign out_info  = done_info_reg;
    assign u_coord   = coord_reg[0];
    assign v_coord   = coord_reg[1];

endmodule

// File: rtl/core/cube_map_face_and_uv.sv
// done follows the face select register, the divider stages and the output register.
// Throughput: one item per clock; busy stays low and the receiver cannot stall.
// Depth is set by the divider pipeline: one quotient bit per stage for both u and v.
// Reset: rst_n asynchronous, active low, clears all valid bits; no item is in flight.
// A zero direction gives face 5, zero_dir high and u = v = one half.
`include "cube_map_face_and_uv_macros.svh"

module cube_map_face_and_uv #(
    parameter int COMP_BITS    = 16,
    parameter int UV_FRAC_BITS = 16
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic signed [COMP_BITS-1:0] dir_x,
    input  logic signed [COMP_BITS-1:0] dir_y,
    input  logic signed [COMP_BITS-1:0] dir_z,
    output logic                        done,
    output logic [2:0]                  face,
    output logic [UV_FRAC_BITS:0]       u_coord,
    output logic [UV_FRAC_BITS:0]       v_coord,
    output logic                        zero_dir
);

    localparam int LATENCY = UV_FRAC_BITS + 3;
    localparam logic [UV_FRAC_BITS:0] UV_HALF = (UV_FRAC_BITS + 1)'(1) << (UV_FRAC_BITS - 1);
    localparam logic [UV_FRAC_BITS:0] UV_ONE  = (UV_FRAC_BITS + 1)'(1) << UV_FRAC_BITS;

    logic                        fs_valid;
    cmuv_pkg::info_t             fs_info;
    logic [COMP_BITS-1:0]        fs_major;
    logic signed [COMP_BITS:0]   fs_comp_u;
    logic signed [COMP_BITS:0]   fs_comp_v;
    cmuv_pkg::info_t             out_info;

    assign busy = 1'b0;

    cmuv_face_sel #(
        .COMP_BITS (COMP_BITS)
    ) u_face_sel (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (start && !busy),
        .dir_x     (dir_x),
        .dir_y     (dir_y),
        .dir_z     (dir_z),
        .out_valid (fs_valid),
        .out_info  (fs_info),
        .major     (fs_major),
        .comp_u    (fs_comp_u),
        .comp_v    (fs_comp_v)
    );

    cmuv_div_pipe #(
        .COMP_BITS    (COMP_BITS),
        .UV_FRAC_BITS (UV_FRAC_BITS)
    ) u_div_pipe (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (fs_valid),
        .in_info   (fs_info),
        .major     (fs_major),
        .comp_u    (fs_comp_u),
        .comp_v    (fs_comp_v),
        .out_valid (done),
        .out_info  (out_info),
        .u_coord   (u_coord),
        .v_coord   (v_coord)
    );

    assign face     = out_info.face;
    assign zero_dir = out_info.zero;

    `CMUV_ASSERT_IMPLY(a_zero_half, done && zero_dir, u_coord == UV_HALF && v_coord == UV_HALF && face == cmuv_pkg::FACE_POS_Z)
    `CMUV_ASSERT_IMPLY(a_uv_range, done, u_coord <= UV_ONE && v_coord <= UV_ONE)
    `CMUV_ASSERT_DELAY(a_latency, start && !busy, LATENCY, done)

endmodule
